// File: rtl/core/tatl_pkg.sv
// shared types, constants and the q15 blend function for the albedo lookup block
// used by tatl_ctrl, tatl_datapath and the top level
// no dependencies
package tatl_pkg;

    localparam int GRID_SIZE   = 16;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_W       = $clog2(GRID_SIZE);
    localparam int DIR_DEPTH   = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AVG_DEPTH   = GRID_SIZE * GRID_SIZE;
    localparam int DIR_AW      = 3 * IDX_W;
    localparam int AVG_AW      = 2 * IDX_W;
    localparam int ADDR_W      = 12;
    localparam int FRAC_W      = 15;
    localparam int COORD_W     = 16;
    localparam int ETA_W       = 16;
    localparam int INV_W       = 24;
    localparam int PROD_W      = ETA_W + INV_W;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 4;

    localparam logic [COORD_W-1:0] ONE_Q15 = COORD_W'(32768);
    localparam logic [IDX_W-1:0]   IDX_MAX = IDX_W'(GRID_SIZE - 1);

    localparam logic [1:0] KIND_DIR_WRITE = 2'd0;
    localparam logic [1:0] KIND_AVG_WRITE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ETA_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ETA_INV = CFG_IDX_W'(1);

    localparam logic [ETA_W-1:0] ETA_MIN_RESET = ETA_W'(4096);
    localparam logic [INV_W-1:0] ETA_INV_RESET = INV_W'(65536);

    typedef enum logic [2:0] {
        DOP_NONE,
        DOP_LXA,
        DOP_LXB,
        DOP_LYA,
        DOP_LYB,
        DOP_LZ
    } dir_op_t;

    typedef enum logic [1:0] {
        AOP_NONE,
        AOP_LYA,
        AOP_LYB,
        AOP_LZ
    } avg_op_t;

    typedef struct packed {
        logic        take;
        logic        eta_mul;
        logic        split;
        logic [2:0]  dir_corner;
        logic        dir_hold;
        dir_op_t     dir_op;
        logic [1:0]  avg_corner;
        logic        avg_hold;
        avg_op_t     avg_op;
        logic        out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_sts_t;

    function automatic logic [VALUE_BITS-1:0] lerp_q15(
        input logic [VALUE_BITS-1:0] a,
        input logic [VALUE_BITS-1:0] b,
        input logic [FRAC_W-1:0]     f
    );
        logic signed [VALUE_BITS+1:0]        diff;
        logic signed [VALUE_BITS+FRAC_W+2:0] prod;
        logic signed [VALUE_BITS+FRAC_W+2:0] shifted;
        diff    = $signed({2'b00, b}) - $signed({2'b00, a});
        prod    = diff * $signed({1'b0, f});
        shifted = prod >>> FRAC_W;
        return a + shifted[VALUE_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/tatl_ctrl.sv
// sequencer for the albedo lookup: accept, eta scale, split, corner fetch, output
// depends on tatl_pkg
module tatl_ctrl
    import tatl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    [1:0] kind,
    output logic    in_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ETA,
        ST_SPLIT,
        ST_FETCH,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.dir_op = DOP_NONE;
        cmd.avg_op = AOP_NONE;
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid && kind == KIND_LOOKUP)
                    state_next = ST_ETA;
            end
            ST_ETA:
            begin
                cmd.eta_mul = 1'b1;
                state_next  = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                step_next  = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.dir_corner = step_reg[2:0];
                cmd.avg_corner = step_reg[1:0];
                cmd.dir_hold   = (step_reg == 4'd1) || (step_reg == 4'd3) ||
                                 (step_reg == 4'd5) || (step_reg == 4'd7);
                cmd.avg_hold   = (step_reg == 4'd1) || (step_reg == 4'd3);
                case (step_reg)
                    4'd2:    cmd.dir_op = DOP_LXA;
                    4'd4:    cmd.dir_op = DOP_LXB;
                    4'd5:    cmd.dir_op = DOP_LYA;
                    4'd6:    cmd.dir_op = DOP_LXA;
                    4'd8:    cmd.dir_op = DOP_LXB;
                    4'd9:    cmd.dir_op = DOP_LYB;
                    4'd10:   cmd.dir_op = DOP_LZ;
                    default: cmd.dir_op = DOP_NONE;
                endcase
                case (step_reg)
                    4'd2:    cmd.avg_op = AOP_LYA;
                    4'd4:    cmd.avg_op = AOP_LYB;
                    4'd5:    cmd.avg_op = AOP_LZ;
                    default: cmd.avg_op = AOP_NONE;
                endcase
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd10)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_load = !sts.out_full;
                if (!sts.out_full)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: rtl/core/tatl_datapath.sv
// albedo lookup datapath: config registers, both tables, eta scaling,
// axis split, two blend units and the output register; depends on tatl_pkg
module tatl_datapath
    import tatl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [1:0]            kind,
    input  logic [ADDR_W-1:0]     entry_address,
    input  logic [VALUE_BITS-1:0] entry_value,
    input  logic [COORD_W-1:0]    cosine_angle,
    input  logic [COORD_W-1:0]    surface_roughness,
    input  logic [ETA_W-1:0]      refraction_index,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] albedo_dir,
    output logic [VALUE_BITS-1:0] albedo_avg
);

    logic [ETA_W-1:0] eta_min_reg;
    logic [INV_W-1:0] eta_inv_reg;

    logic [VALUE_BITS-1:0] dir_mem [DIR_DEPTH];
    logic [VALUE_BITS-1:0] avg_mem [AVG_DEPTH];
    logic [VALUE_BITS-1:0] dir_rdata_reg, avg_rdata_reg;

    logic [COORD_W-1:0] cos_reg, rough_reg;
    logic [ETA_W-1:0]   eta_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [IDX_W-1:0]  x0_reg, x1_reg, y0_reg, y1_reg, z0_reg, z1_reg;
    logic [FRAC_W-1:0] fx_reg, fy_reg, fz_reg;

    logic [VALUE_BITS-1:0] dhold_reg, xa_reg, xb_reg, ya_reg, yb_reg, d_reg;
    logic [VALUE_BITS-1:0] ahold_reg, aya_reg, ayb_reg, av_reg;
    logic [VALUE_BITS-1:0] out_dir_reg, out_avg_reg;
    logic                  out_valid_reg;

    logic [DIR_AW-1:0] dir_addr;
    logic [AVG_AW-1:0] avg_addr;
    logic              dir_we, avg_we;

    logic [PROD_W-14:0] n_raw;
    logic [COORD_W-1:0] eta_norm;

    logic [IDX_W+FRAC_W-1:0] x_split, y_split, z_split;

    logic [VALUE_BITS-1:0] dl_a, dl_b, dl_res;
    logic [FRAC_W-1:0]     dl_f;
    logic [VALUE_BITS-1:0] al_a, al_b, al_res;
    logic [FRAC_W-1:0]     al_f;

    function automatic logic [IDX_W+FRAC_W-1:0] split_axis(input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0]       cs;
        logic [COORD_W+IDX_W-1:0] p;
        cs = (c > ONE_Q15) ? ONE_Q15 : c;
        p  = (COORD_W+IDX_W)'(cs) * (COORD_W+IDX_W)'(IDX_MAX);
        return p[IDX_W+FRAC_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] upper_idx(input logic [IDX_W-1:0] lo);
        return (lo < IDX_MAX) ? lo + IDX_W'(1) : IDX_MAX;
    endfunction

    assign sts.out_full = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_min_reg <= ETA_MIN_RESET;
            eta_inv_reg <= ETA_INV_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ETA_MIN: eta_min_reg <= cfg_data[ETA_W-1:0];
                REG_ETA_INV: eta_inv_reg <= cfg_data[INV_W-1:0];
                default:     ;
            endcase
        end
    end

    assign dir_we = cmd.take && (kind == KIND_DIR_WRITE);
    assign avg_we = cmd.take && (kind == KIND_AVG_WRITE) &&
                    (entry_address < ADDR_W'(AVG_DEPTH));

    assign dir_addr = {cmd.dir_corner[2] ? z1_reg : z0_reg,
                       cmd.dir_corner[1] ? y1_reg : y0_reg,
                       cmd.dir_corner[0] ? x1_reg : x0_reg};
    assign avg_addr = {cmd.avg_corner[1] ? z1_reg : z0_reg,
                       cmd.avg_corner[0] ? y1_reg : y0_reg};

    always_ff @(posedge clk)
    begin
        if (dir_we)
            dir_mem[entry_address[DIR_AW-1:0]] <= entry_value;
        dir_rdata_reg <= dir_mem[dir_addr];
    end

    always_ff @(posedge clk)
    begin
        if (avg_we)
            avg_mem[entry_address[AVG_AW-1:0]] <= entry_value;
        avg_rdata_reg <= avg_mem[avg_addr];
    end

    assign n_raw    = prod_reg[PROD_W-1:13];
    assign eta_norm = (n_raw > (PROD_W-13)'(ONE_Q15)) ? ONE_Q15 : n_raw[COORD_W-1:0];

    assign x_split = split_axis(cos_reg);
    assign y_split = split_axis(rough_reg);
    assign z_split = split_axis(eta_norm);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cos_reg   <= cosine_angle;
            rough_reg <= surface_roughness;
            eta_reg   <= refraction_index;
        end
        if (cmd.eta_mul)
        begin
            if (eta_reg > eta_min_reg)
                prod_reg <= PROD_W'(eta_reg - eta_min_reg) * PROD_W'(eta_inv_reg);
            else
                prod_reg <= '0;
        end
        if (cmd.split)
        begin
            {x0_reg, fx_reg} <= x_split;
            {y0_reg, fy_reg} <= y_split;
            {z0_reg, fz_reg} <= z_split;
            x1_reg <= upper_idx(x_split[IDX_W+FRAC_W-1:FRAC_W]);
            y1_reg <= upper_idx(y_split[IDX_W+FRAC_W-1:FRAC_W]);
            z1_reg <= upper_idx(z_split[IDX_W+FRAC_W-1:FRAC_W]);
        end
    end

    // directional blend unit
    always_comb
    begin
        case (cmd.dir_op)
            DOP_LXA, DOP_LXB:
            begin
                dl_a = dhold_reg;
                dl_b = dir_rdata_reg;
                dl_f = fx_reg;
            end
            DOP_LYA, DOP_LYB:
            begin
                dl_a = xa_reg;
                dl_b = xb_reg;
                dl_f = fy_reg;
            end
            default:
            begin
                dl_a = ya_reg;
                dl_b = yb_reg;
                dl_f = fz_reg;
            end
        endcase
        dl_res = lerp_q15(dl_a, dl_b, dl_f);
    end

    // average blend unit
    always_comb
    begin
        case (cmd.avg_op)
            AOP_LYA, AOP_LYB:
            begin
                al_a = ahold_reg;
                al_b = avg_rdata_reg;
                al_f = fy_reg;
            end
            default:
            begin
                al_a = aya_reg;
                al_b = ayb_reg;
                al_f = fz_reg;
            end
        endcase
        al_res = lerp_q15(al_a, al_b, al_f);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dir_hold)
            dhold_reg <= dir_rdata_reg;
        if (cmd.avg_hold)
            ahold_reg <= avg_rdata_reg;
        case (cmd.dir_op)
            DOP_LXA: xa_reg <= dl_res;
            DOP_LXB: xb_reg <= dl_res;
            DOP_LYA: ya_reg <= dl_res;
            DOP_LYB: yb_reg <= dl_res;
            DOP_LZ:  d_reg  <= dl_res;
            default: ;
        endcase
        case (cmd.avg_op)
            AOP_LYA: aya_reg <= al_res;
            AOP_LYB: ayb_reg <= al_res;
            AOP_LZ:  av_reg  <= al_res;
            default: ;
        endcase
        if (cmd.out_load)
        begin
            out_dir_reg <= d_reg;
            out_avg_reg <= av_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign albedo_dir = out_dir_reg;
    assign albedo_avg = out_avg_reg;

endmodule

// File: rtl/core/trilinear_albedo_table_lookup_unit.sv
// top level of the albedo table lookup block
// depends on tatl_pkg, tatl_ctrl and tatl_datapath
//
// input channel (in_valid/in_stall) carries one beat per item: kind selects
// a directional table write, an average table write or a lookup.
// a write beat leaves the input unstalled and gives no result beat.
// a lookup's result beat comes on the output channel (out_valid/out_stall)
// after the eta product, the axis split, the eight directional corner reads
// through the single read port of the directional table and the load of the
// output register; the next item can be taken in the same cycle in which the
// result is first offered, and no new item is taken while a lookup is in flight.
// the output register holds a finished result while the receiver stalls;
// writes are still taken then, and the next lookup only waits for the
// output register to free up at its end.
// cfg_write/cfg_index/cfg_data set eta_minimum (index 0) and
// eta_inverse_range (index 1); write them only while the block is idle.
// reset clears the sequencer and output valid and restores the register
// defaults; table contents are undefined until written.
module trilinear_albedo_table_lookup_unit
    import tatl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [ADDR_W-1:0]     entry_address,
    input  logic [VALUE_BITS-1:0] entry_value,
    input  logic [COORD_W-1:0]    cosine_angle,
    input  logic [COORD_W-1:0]    surface_roughness,
    input  logic [ETA_W-1:0]      refraction_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] albedo_dir,
    output logic [VALUE_BITS-1:0] albedo_avg,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    tatl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tatl_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .kind               (kind),
        .entry_address      (entry_address),
        .entry_value        (entry_value),
        .cosine_angle       (cosine_angle),
        .surface_roughness  (surface_roughness),
        .refraction_index   (refraction_index),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .albedo_dir         (albedo_dir),
        .albedo_avg         (albedo_avg)
    );

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_LOOKUP |=> in_stall)
        else $error("lookup beat did not start the sequencer");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != KIND_LOOKUP |=> !in_stall)
        else $error("write beat stalled the input");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat appeared without a lookup in flight");

endmodule

// File: test/tb_trilinear_albedo_table_lookup_unit.sv
// testbench for the albedo table lookup block: table loads, lookups and register settings
// predicts every lookup with its own fixed-point interpolation and checks each result beat
// depends on tatl_pkg and trilinear_albedo_table_lookup_unit
module tb_trilinear_albedo_table_lookup_unit;
    import tatl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST = GRID_SIZE - 1;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);

    typedef struct packed {
        logic [VALUE_BITS-1:0] dir;
        logic [VALUE_BITS-1:0] avg;
    } albedo_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     entry_address;
    logic [VALUE_BITS-1:0] entry_value;
    logic [COORD_W-1:0]    cosine_angle;
    logic [COORD_W-1:0]    surface_roughness;
    logic [ETA_W-1:0]      refraction_index;
    logic                  out_valid;
    logic                  out_stall;
    logic [VALUE_BITS-1:0] albedo_dir;
    logic [VALUE_BITS-1:0] albedo_avg;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    logic [VALUE_BITS-1:0] dir_ref [DIR_DEPTH];
    logic [VALUE_BITS-1:0] avg_ref [AVG_DEPTH];
    bit                    dir_seen [DIR_DEPTH];
    bit                    avg_seen [AVG_DEPTH];
    logic [ETA_W-1:0]      eta_min;
    logic [INV_W-1:0]      eta_inv;
    albedo_t               pending_albedo[$];
    int                    errors;
    int                    idle_cycles;
    bit                    timed_out;

    trilinear_albedo_table_lookup_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint blend(longint a, longint b, int f);
        return (a * (32768 - f) + b * f) >>> 15;
    endfunction

    function automatic void split(int c, output int lo, output int hi, output int f);
        int p;
        if (c > 32768)
            c = 32768;
        p = c * LAST;
        lo = p >> 15;
        f = p & 32767;
        hi = (lo + 1 < LAST) ? lo + 1 : LAST;
    endfunction

    function automatic int eta_coord(int e);
        longint n;
        if (e > eta_min)
        begin
            n = (longint'(e - eta_min) * longint'(eta_inv)) >>> 13;
            return (n > 32768) ? 32768 : int'(n);
        end
        return 0;
    endfunction

    function automatic longint dir_at(int x, int y, int z);
        return dir_ref[(z * GRID_SIZE + y) * GRID_SIZE + x];
    endfunction

    // true when every entry the lookup reads has been written
    function automatic bit lookup_safe(int c, int r, int e);
        int x0, x1, fx, y0, y1, fy, z0, z1, fz;
        int xi, yi, zi;
        bit ok;
        ok = 1'b1;
        split(c, x0, x1, fx);
        split(r, y0, y1, fy);
        split(eta_coord(e), z0, z1, fz);
        for (int k = 0; k < 8; k++)
        begin
            xi = k[0] ? x1 : x0;
            yi = k[1] ? y1 : y0;
            zi = k[2] ? z1 : z0;
            if (!dir_seen[(zi * GRID_SIZE + yi) * GRID_SIZE + xi])
                ok = 1'b0;
        end
        for (int k = 0; k < 4; k++)
        begin
            yi = k[0] ? y1 : y0;
            zi = k[1] ? z1 : z0;
            if (!avg_seen[zi * GRID_SIZE + yi])
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic albedo_t predict_albedo(int c, int r, int e);
        int x0, x1, fx, y0, y1, fy, z0, z1, fz, en;
        longint q, s, d, a0, a1, av;
        albedo_t res;
        en = eta_coord(e);
        split(c, x0, x1, fx);
        split(r, y0, y1, fy);
        split(en, z0, z1, fz);
        q = blend(blend(dir_at(x0, y0, z0), dir_at(x1, y0, z0), fx),
                  blend(dir_at(x0, y1, z0), dir_at(x1, y1, z0), fx), fy);
        s = blend(blend(dir_at(x0, y0, z1), dir_at(x1, y0, z1), fx),
                  blend(dir_at(x0, y1, z1), dir_at(x1, y1, z1), fx), fy);
        d = blend(q, s, fz);
        a0 = blend(avg_ref[z0 * GRID_SIZE + y0], avg_ref[z0 * GRID_SIZE + y1], fy);
        a1 = blend(avg_ref[z1 * GRID_SIZE + y0], avg_ref[z1 * GRID_SIZE + y1], fy);
        av = blend(a0, a1, fz);
        res.dir = d[VALUE_BITS-1:0];
        res.avg = av[VALUE_BITS-1:0];
        return res;
    endfunction

    task automatic send_beat(logic [1:0] k, int addr, int val, int c, int r, int e);
        int gap;
        int a12, cm, rm, em;
        a12 = addr & 'hfff;
        cm = c & 'hffff;
        rm = r & 'hffff;
        em = e & 'hffff;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        entry_address <= ADDR_W'(a12);
        entry_value <= VALUE_BITS'(val);
        cosine_angle <= COORD_W'(cm);
        surface_roughness <= COORD_W'(rm);
        refraction_index <= ETA_W'(em);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (k)
            KIND_DIR_WRITE:
            begin
                dir_ref[a12] = VALUE_BITS'(val);
                dir_seen[a12] = 1'b1;
            end
            KIND_AVG_WRITE:
            begin
                if (a12 < AVG_DEPTH)
                begin
                    avg_ref[a12] = VALUE_BITS'(val);
                    avg_seen[a12] = 1'b1;
                end
            end
            KIND_LOOKUP:    pending_albedo.push_back(predict_albedo(cm, rm, em));
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_albedo.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ETA_MIN)
            eta_min = ETA_W'(val);
        else if (idx == REG_ETA_INV)
            eta_inv = INV_W'(val);
    endtask

    task automatic rand_coord(output int v);
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 32768;
            2: v = $urandom_range(32769, 65535);
            default: v = $urandom_range(0, 32768);
        endcase
    endtask

    // eta is redrawn up to 16 times until the lookup stays on written entries, else set to zero; zero always does
    task automatic rand_lookup();
        int c, r, e, tries;
        rand_coord(c);
        rand_coord(r);
        e = $urandom_range(0, 65535);
        tries = 0;
        while (!lookup_safe(c, r, e) && tries < 16)
        begin
            e = $urandom_range(0, 65535);
            tries++;
        end
        if (!lookup_safe(c, r, e))
            e = 0;
        send_beat(KIND_LOOKUP, $urandom, $urandom, c, r, e);
    endtask

    // loads the lowest two and the top eta planes of both tables
    task automatic test_fill_tables();
        for (int z = 0; z < GRID_SIZE; z++)
        begin
            if (z == 0 || z == 1 || z == LAST)
            begin
                for (int a = 0; a < GRID_SIZE * GRID_SIZE; a++)
                    send_beat(KIND_DIR_WRITE, z * GRID_SIZE * GRID_SIZE + a, $urandom,
                              $urandom, $urandom, $urandom);
                for (int y = 0; y < GRID_SIZE; y++)
                    send_beat(KIND_AVG_WRITE, z * GRID_SIZE + y, $urandom,
                              $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_directed();
        send_beat(KIND_DIR_WRITE, 0, 16'hffff, 0, 0, 0);
        send_beat(KIND_DIR_WRITE, DIR_DEPTH - 1, 0, 0, 0, 0);
        send_beat(KIND_AVG_WRITE, AVG_DEPTH - 1, 16'hffff, 0, 0, 0);
        send_beat(KIND_AVG_WRITE, AVG_DEPTH, 16'h1234, 0, 0, 0);
        send_beat(KIND_AVG_WRITE, 4095, 16'h4321, 0, 0, 0);
        send_beat(KIND_UNUSED, 5, 5, 100, 100, 5000);
        send_beat(KIND_LOOKUP, 0, 0, 0, 0, 0);
        send_beat(KIND_LOOKUP, 0, 0, 32768, 32768, 65535);
        send_beat(KIND_LOOKUP, 0, 0, 65535, 65535, 4096);
        send_beat(KIND_LOOKUP, 0, 0, 32767, 1, 4097);
        send_beat(KIND_LOOKUP, 0, 0, 16384, 16384, 4300);
        send_beat(KIND_LOOKUP, 0, 0, 1, 32767, 8192);
        send_beat(KIND_LOOKUP, 0, 0, 2184, 30583, 4095);
    endtask

    task automatic test_registers();
        write_reg(REG_ETA_MIN, 0);
        write_reg(REG_ETA_INV, 24'hffffff);
        repeat (8) rand_lookup();
        write_reg(REG_ETA_MIN, 65535);
        write_reg(REG_ETA_INV, 0);
        repeat (6) rand_lookup();
        write_reg(REG_NONE, 24'h00abcd);
        repeat (4) rand_lookup();
        write_reg(REG_ETA_MIN, 2048);
        write_reg(REG_ETA_INV, 9000);
        repeat (8) rand_lookup();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_beat(KIND_DIR_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
                1: send_beat(KIND_AVG_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
                2: send_beat(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: rand_lookup();
            endcase
            if (i % 400 == 399)
            begin
                drain();
                write_reg(REG_ETA_MIN, $urandom_range(0, 65535));
                write_reg(REG_ETA_INV, $urandom_range(0, 24'hffffff));
            end
        end
    endtask

    always @(posedge clk)
    begin
        albedo_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_albedo.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_albedo.pop_front();
                if (albedo_dir !== want.dir)
                begin
                    $error("albedo_dir expected %0d actual %0d", want.dir, albedo_dir);
                    errors++;
                end
                if (albedo_avg !== want.avg)
                begin
                    $error("albedo_avg expected %0d actual %0d", want.avg, albedo_avg);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int wait_left;
        out_stall = 1'b0;
        forever
        begin
            wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (wait_left != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_left) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT && !timed_out)
            timed_out = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_LOOKUP;
        entry_address = '0;
        entry_value = '0;
        cosine_angle = '0;
        surface_roughness = '0;
        refraction_index = '0;
        cfg_write = 1'b0;
        cfg_index = REG_ETA_MIN;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        eta_min = ETA_MIN_RESET;
        eta_inv = ETA_INV_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
        begin
            test_fill_tables();
            test_directed();
            drain();
            test_registers();
            test_random(900);
            drain();
        end
        wait (timed_out);
        join_any
        if (timed_out)
            $display("trilinear_albedo_table_lookup_unit test failed");
        else if (errors == 0 && pending_albedo.size() == 0)
            $display("trilinear_albedo_table_lookup_unit test passed");
        else
            $display("trilinear_albedo_table_lookup_unit test failed");
        $finish;
    end
endmodule
